// ----- sv/dtf_pkg.sv -----
// Package for the decimal text to single-precision converter.
// Holds the request and result payload types and the scaling constants.
// No dependencies.
package dtf_pkg;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       field_start;
  } dtf_in_t;

  typedef struct packed {
    logic        parse_ok;
    logic [31:0] value_bits;
    logic [7:0]  consumed;
  } dtf_out_t;

  // ASCII codes
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Double-precision scale factors: 53-bit significand and unbiased exponent
  localparam logic [52:0]        K01_MANT = 53'h147AE147AE147B;  // 0.01
  localparam logic signed [9:0]  K01_EXP  = -10'sd7;
  localparam logic [52:0]        K1_MANT  = 53'h1999999999999A;  // 0.1
  localparam logic signed [9:0]  K1_EXP   = -10'sd4;
  localparam logic [52:0]        K10_MANT = 53'h14000000000000;  // 10.0
  localparam logic signed [9:0]  K10_EXP  = 10'sd3;

  localparam logic signed [9:0]  FLT_MAX_EXP = 10'sd127;
  localparam logic signed [9:0]  FLT_BIAS    = 10'sd127;

endpackage

// ----- sv/dtf_scale.sv -----
// Integer to single conversion and decimal scaling on one shared multiplier.
// Normalizes one bit per cycle, then multiplies by 0.01, 0.1 or 10 in double
// precision from two partial products, rounding to double and then to single.
// Depends on dtf_pkg.
module dtf_scale
  import dtf_pkg::*;
#(
  parameter int MANT_W = 27
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [MANT_W-1:0]   mant,
  input  logic signed [7:0]   dec_exp,
  input  logic                neg,
  output logic                done,
  output logic [31:0]         bits
);

  typedef enum logic [3:0] {
    S_IDLE, S_NORM, S_RND, S_PICK, S_MLO, S_MHI, S_R53, S_R24, S_DONE
  } st_t;

  typedef enum logic [1:0] {K_01, K_1, K_10} kidx_t;

  st_t                st;
  kidx_t              kidx;
  logic [31:0]        nrm;
  logic [23:0]        fm;
  logic signed [9:0]  fe;
  logic signed [7:0]  de;
  logic               inf;
  logic               zero;
  logic               sgn;
  logic [49:0]        plo;
  logic [76:0]        prod;
  logic [52:0]        dm;

  logic [52:0]        k_mant;
  logic signed [9:0]  k_exp;
  logic [26:0]        mul_b;
  logic [50:0]        mul_p;

  always_comb begin
    case (kidx)
      K_01:    begin k_mant = K01_MANT; k_exp = K01_EXP; end
      K_1:     begin k_mant = K1_MANT;  k_exp = K1_EXP;  end
      K_10:    begin k_mant = K10_MANT; k_exp = K10_EXP; end
      default: begin k_mant = K10_MANT; k_exp = K10_EXP; end
    endcase
  end

  // shared multiplier: low constant half first, then high half
  assign mul_b = (st == S_MLO) ? {1'b0, k_mant[25:0]} : k_mant[52:26];
  assign mul_p = fm * mul_b;

  // round-to-nearest-even helpers
  logic        r53_top;
  logic [52:0] r53_keep;
  logic        r53_g, r53_s;
  logic [53:0] r53_sum;
  logic [23:0] r24_keep;
  logic        r24_g, r24_s;
  logic [24:0] r24_sum;

  always_comb begin
    r53_top  = prod[76];
    r53_keep = r53_top ? prod[76:24] : prod[75:23];
    r53_g    = r53_top ? prod[23] : prod[22];
    r53_s    = r53_top ? (|prod[22:0]) : (|prod[21:0]);
    r53_sum  = {1'b0, r53_keep} + {53'd0, r53_g & (r53_s | r53_keep[0])};
    if (st == S_RND) begin
      r24_keep = nrm[31:8];
      r24_g    = nrm[7];
      r24_s    = |nrm[6:0];
    end else begin
      r24_keep = dm[52:29];
      r24_g    = dm[28];
      r24_s    = |dm[27:0];
    end
    r24_sum = {1'b0, r24_keep} + {24'd0, r24_g & (r24_s | r24_keep[0])};
  end

  logic signed [9:0] fe_rnd;
  assign fe_rnd = fe + {9'd0, r24_sum[24]};

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (st)
        S_IDLE: begin
          if (start) begin
            nrm  <= {{(32-MANT_W){1'b0}}, mant};
            fe   <= 10'sd31;
            de   <= dec_exp;
            sgn  <= neg;
            inf  <= 1'b0;
            zero <= (mant == '0);
            st   <= (mant == '0) ? S_DONE : S_NORM;
          end
        end
        S_NORM: begin
          if (nrm[31]) begin
            st <= S_RND;
          end else begin
            nrm <= {nrm[30:0], 1'b0};
            fe  <= fe - 10'sd1;
          end
        end
        S_RND, S_R24: begin
          fm <= r24_sum[24] ? r24_sum[24:1] : r24_sum[23:0];
          fe <= fe_rnd;
          if (fe_rnd > FLT_MAX_EXP) inf <= 1'b1;
          st <= S_PICK;
        end
        S_PICK: begin
          if (inf || de == 8'sd0) begin
            st <= S_DONE;
          end else if (de <= -8'sd2) begin
            kidx <= K_01;
            de   <= de + 8'sd2;
            st   <= S_MLO;
          end else if (de < 8'sd0) begin
            kidx <= K_1;
            de   <= 8'sd0;
            st   <= S_MLO;
          end else begin
            kidx <= K_10;
            de   <= de - 8'sd1;
            st   <= S_MLO;
          end
        end
        S_MLO: begin
          plo <= mul_p[49:0];
          st  <= S_MHI;
        end
        S_MHI: begin
          prod <= {mul_p, 26'd0} + {27'd0, plo};
          st   <= S_R53;
        end
        S_R53: begin
          dm <= r53_sum[53] ? r53_sum[53:1] : r53_sum[52:0];
          fe <= fe + k_exp + {9'd0, r53_top} + {9'd0, r53_sum[53]};
          st <= S_R24;
        end
        S_DONE: begin
          if (zero) begin
            bits <= {sgn, 31'd0};
          end else if (inf) begin
            bits <= {sgn, 8'hFF, 23'd0};
          end else begin
            bits <= {sgn, 8'(fe + FLT_BIAS), fm[22:0]};
          end
          done <= 1'b1;
          st   <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/decimal_text_to_float.sv -----
// Top level: streaming ASCII decimal number parser with single-precision result.
// Parses one byte per request, then converts through dtf_scale.
// Depends on dtf_pkg and dtf_scale.
//
//   channel | direction | payload    | handshake
//   in      | request   | dtf_in_t   | in_valid / in_stall
//   out     | result    | dtf_out_t  | out_valid / out_stall
//
// A byte that does not end the field leaves in_stall low.
// The terminating byte starts the conversion: normalize and round to single,
// then per decimal scaling step on the shared multiplier a low and a high
// multiply and two roundings (up to 127 steps, fewer once the value overflows).
// in_stall stays high from the terminating byte until the result is loaded
// into the output register; a stalled result holds the unit in that wait.
// rst is synchronous and clears the parser and both sequencers.
module decimal_text_to_float
  import dtf_pkg::*;
#(
  parameter int SIG_DIGITS    = 8,
  parameter int MAX_FIELD_LEN = 255
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  dtf_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output dtf_out_t out_data
);

  localparam int MANT_W = $clog2(10 ** SIG_DIGITS);

  typedef enum logic [1:0] {P_IDLE, P_FIRST, P_BODY, P_DONE} phase_t;
  typedef enum logic [1:0] {T_PARSE, T_CALC, T_OUT} top_t;

  phase_t             phase;
  top_t               tstate;
  logic               is_negative;
  logic [MANT_W-1:0]  mantissa;
  logic signed [7:0]  dec_exponent;
  logic [7:0]         digit_count;
  logic               seen_point;
  logic [7:0]         position;
  logic               sc_start;

  phase_t             phase_next;
  logic               neg_next;
  logic [MANT_W-1:0]  mant_next;
  logic signed [7:0]  exp_next;
  logic [7:0]         cnt_next;
  logic               pt_next;
  logic [7:0]         pos_next;
  logic               fin;

  logic               sc_done;
  logic [31:0]        sc_bits;
  logic               accept;
  logic               out_free;

  assign in_stall = (tstate != T_PARSE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    logic       handled;
    logic       is_digit;
    logic [7:0] c;
    c          = in_data.text_byte;
    handled    = 1'b0;
    is_digit   = (c >= CH_ZERO) && (c <= CH_NINE);
    phase_next = phase;
    neg_next   = is_negative;
    mant_next  = mantissa;
    exp_next   = dec_exponent;
    cnt_next   = digit_count;
    pt_next    = seen_point;
    pos_next   = position;
    fin        = 1'b0;
    if (in_data.field_start) begin
      phase_next = P_FIRST;
      neg_next   = 1'b0;
      mant_next  = '0;
      exp_next   = '0;
      cnt_next   = '0;
      pt_next    = 1'b0;
      pos_next   = '0;
    end
    if (phase_next == P_FIRST || phase_next == P_BODY) begin
      if (pos_next >= 8'(MAX_FIELD_LEN)) begin
        fin = 1'b1;
      end else begin
        if (phase_next == P_FIRST) begin
          phase_next = P_BODY;
          if (c == CH_MINUS || c == CH_PLUS) begin
            neg_next = (c == CH_MINUS);
            pos_next = pos_next + 8'd1;
            handled  = 1'b1;
          end
        end
        if (!handled) begin
          if (is_digit) begin
            if (cnt_next != 8'hFF) cnt_next = cnt_next + 8'd1;
            if (cnt_next <= 8'(SIG_DIGITS)) begin
              if (pt_next) exp_next = exp_next - 8'sd1;
              mant_next = (mant_next << 3) + (mant_next << 1)
                          + MANT_W'(c - CH_ZERO);
            end else if (!pt_next && exp_next < 8'sd127) begin
              exp_next = exp_next + 8'sd1;
            end
            pos_next = pos_next + 8'd1;
          end else if (c == CH_POINT && !pt_next) begin
            pt_next  = 1'b1;
            pos_next = pos_next + 8'd1;
          end else begin
            fin = 1'b1;
          end
        end
      end
      if (fin) phase_next = P_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= P_IDLE;
      tstate       <= T_PARSE;
      is_negative  <= 1'b0;
      mantissa     <= '0;
      dec_exponent <= '0;
      digit_count  <= '0;
      seen_point   <= 1'b0;
      position     <= '0;
      sc_start     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      sc_start <= 1'b0;
      if (out_valid && !out_stall && tstate != T_OUT) out_valid <= 1'b0;
      case (tstate)
        T_PARSE: begin
          if (accept) begin
            phase        <= phase_next;
            is_negative  <= neg_next;
            mantissa     <= mant_next;
            dec_exponent <= exp_next;
            digit_count  <= cnt_next;
            seen_point   <= pt_next;
            position     <= pos_next;
            if (fin) begin
              tstate   <= T_CALC;
              sc_start <= 1'b1;
            end
          end
        end
        T_CALC: begin
          if (sc_done) tstate <= T_OUT;
        end
        T_OUT: begin
          // hold until the output register frees up
          if (out_free) begin
            out_data.parse_ok   <= (digit_count != 8'd0);
            out_data.value_bits <= sc_bits;
            out_data.consumed   <= position;
            out_valid           <= 1'b1;
            tstate              <= T_PARSE;
          end
        end
        default: tstate <= T_PARSE;
      endcase
    end
  end

  dtf_scale #(
    .MANT_W(MANT_W)
  ) u_scale (
    .clk     (clk),
    .rst     (rst),
    .start   (sc_start),
    .mant    (mantissa),
    .dec_exp (dec_exponent),
    .neg     (is_negative && (digit_count != 8'd0)),
    .done    (sc_done),
    .bits    (sc_bits)
  );

  a_done_in_calc: assert property (@(posedge clk) disable iff (rst)
    sc_done |-> tstate == T_CALC)
    else $error("conversion finished outside the calc state");

  a_fail_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.parse_ok |-> out_data.value_bits == 32'd0)
    else $error("failed parse carries a nonzero value");

  a_calc_after_done: assert property (@(posedge clk) disable iff (rst)
    tstate != T_PARSE |-> phase == P_DONE)
    else $error("converting while the field is still open");

  a_start_from_parse: assert property (@(posedge clk) disable iff (rst)
    sc_start |-> tstate == T_CALC && $past(tstate) == T_PARSE)
    else $error("conversion launched without a terminating byte");

endmodule
